### hdl/tgbp_pkg.sv
package tgbp_pkg;

    localparam int TABLE_COUNT_DEF       = 4;
    localparam int INDEX_BITS_DEF        = 10;
    localparam int BASE_INDEX_BITS_DEF   = 12;
    localparam int TAG_WIDTH_DEF         = 9;
    localparam int HISTORY_BITS_DEF      = 64;
    localparam int PRED_COUNTER_BITS_DEF = 3;

    localparam int LEN_WIDTH  = 7;
    localparam int LEN_REGS   = 4;
    localparam int IN_WIDTH   = 72;
    localparam int OUT_WIDTH  = 8;

    typedef enum logic [1:0] {
        CFG_LEN_T0 = 2'd0,
        CFG_LEN_T1 = 2'd1,
        CFG_LEN_T2 = 2'd2,
        CFG_LEN_T3 = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_PREDICT = 1'b0,
        OP_UPDATE  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PRED,
        ST_UPD1,
        ST_UPD2
    } state_t;

endpackage

### hdl/tagged_geometric_branch_predictor_core.sv
// Tagged geometric-history branch direction predictor.
//
// Items enter on the s_axis channel. tuser carries the operation (0 predict,
// 1 update) and tdata carries the branch address and, for an update, the
// resolved direction. A predict item yields one result item on m_axis with
// the predicted direction, whether a tagged table provided it and which one.
// An update item yields no result; it trains the counters of the entry that
// the last prediction matched by tag (else its base entry), allocates or ages
// entries on a mispredict, and shifts the outcome into the global history.
//
// A predict item first reads the base table and every tagged table, then
// picks the provider and loads the output register.
// An update ends after the training write when the prediction was right;
// when it was wrong an allocation write follows the training write and,
// where a tagged entry was trained, its table is read again at the
// allocation index. The single read port of each table memory sets this.
//
// After reset the tables are swept to zero, one row a cycle, through
// 2**max(BASE_INDEX_BITS, INDEX_BITS) row addresses (4096 with the defaults);
// s_axis_tready stays low meanwhile, while configuration writes are taken.
// If the receiver stalls, the result is held in the output register and the
// next item is still accepted; a following prediction waits until the
// output register is free.
module tagged_geometric_branch_predictor_core
    import tgbp_pkg::*;
#(
    parameter int TABLE_COUNT       = TABLE_COUNT_DEF,
    parameter int INDEX_BITS        = INDEX_BITS_DEF,
    parameter int BASE_INDEX_BITS   = BASE_INDEX_BITS_DEF,
    parameter int TAG_WIDTH         = TAG_WIDTH_DEF,
    parameter int HISTORY_BITS      = HISTORY_BITS_DEF,
    parameter int PRED_COUNTER_BITS = PRED_COUNTER_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // bits from lowest: pc[63:0], taken, zero fill
    input  logic [IN_WIDTH-1:0]   s_axis_tdata,
    // bits from lowest: opcode
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // bits from lowest: predict_taken, from_tagged, provider_table[1:0], zero fill
    output logic [OUT_WIDTH-1:0]  m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [LEN_WIDTH-1:0]  cfg_data
);

    localparam int TW       = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int CW       = (BASE_INDEX_BITS > INDEX_BITS) ? BASE_INDEX_BITS : INDEX_BITS;
    localparam int PB       = PRED_COUNTER_BITS;
    localparam logic [PB-1:0] PRED_MAX = {PB{1'b1}};
    localparam logic [PB-1:0] PRED_MID = PRED_MAX >> 1;
    localparam int BASE_DEPTH = 1 << BASE_INDEX_BITS;
    localparam int TBL_DEPTH  = 1 << INDEX_BITS;

    // Fold history bit i < len onto bit i mod INDEX_BITS; 0 if len <= INDEX_BITS.
    function automatic logic [INDEX_BITS-1:0] fold_hist(logic [HISTORY_BITS-1:0] h,
                                                       logic [LEN_WIDTH-1:0] len);
        logic [INDEX_BITS-1:0] acc;
        acc = '0;
        if (int'(len) > INDEX_BITS) begin
            for (int i = 0; i < HISTORY_BITS; i++) begin
                if (i < int'(len)) begin
                    acc[i % INDEX_BITS] = acc[i % INDEX_BITS] ^ h[i];
                end
            end
        end
        return acc;
    endfunction

    function automatic logic [TAG_WIDTH-1:0] tag_hist(logic [HISTORY_BITS-1:0] h,
                                                     logic [LEN_WIDTH-1:0] len);
        logic [HISTORY_BITS+TAG_WIDTH-1:0] he;
        logic [TAG_WIDTH-1:0] acc;
        he  = {{TAG_WIDTH{1'b0}}, h};
        acc = '0;
        for (int i = 0; i < TAG_WIDTH; i++) begin
            if (i < int'(len) && i < HISTORY_BITS) begin
                acc[i] = he[i];
            end
        end
        return acc;
    endfunction

    function automatic logic [PB-1:0] bump_pred(logic [PB-1:0] v, logic up);
        if (up) begin
            return (v < PRED_MAX) ? v + 1'b1 : v;
        end
        return (v != '0) ? v - 1'b1 : v;
    endfunction

    function automatic logic [1:0] bump2(logic [1:0] v, logic up);
        if (up) begin
            return (v != 2'd3) ? v + 2'd1 : v;
        end
        return (v != 2'd0) ? v - 2'd1 : v;
    endfunction

    // Memories and their read registers.
    logic [1:0]           base_mem [BASE_DEPTH];
    logic [TAG_WIDTH-1:0] tag_mem  [TABLE_COUNT][TBL_DEPTH];
    logic [PB-1:0]        pred_mem [TABLE_COUNT][TBL_DEPTH];
    logic [1:0]           use_mem  [TABLE_COUNT][TBL_DEPTH];

    logic [1:0]           rd_base;
    logic [TAG_WIDTH-1:0] rd_tag  [TABLE_COUNT];
    logic [PB-1:0]        rd_pred [TABLE_COUNT];
    logic [1:0]           rd_use  [TABLE_COUNT];

    logic                       base_re, base_we;
    logic [BASE_INDEX_BITS-1:0] base_raddr, base_waddr;
    logic [1:0]                 base_wdata;
    logic                       tbl_re [TABLE_COUNT];
    logic                       tbl_we [TABLE_COUNT];
    logic [INDEX_BITS-1:0]      tbl_raddr [TABLE_COUNT];
    logic [INDEX_BITS-1:0]      tbl_waddr [TABLE_COUNT];
    logic [TAG_WIDTH-1:0]       tbl_wtag  [TABLE_COUNT];
    logic [PB-1:0]              tbl_wpred [TABLE_COUNT];
    logic [1:0]                 tbl_wuse  [TABLE_COUNT];

    // Control and context registers.
    state_t                     state_reg, state_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [HISTORY_BITS-1:0]    hist_reg, hist_next;
    logic [LEN_WIDTH-1:0]       len_reg [LEN_REGS];
    logic                       op_reg, op_next;
    logic                       taken_reg, taken_next;
    logic [BASE_INDEX_BITS-1:0] bidx_reg, bidx_next;
    logic [INDEX_BITS-1:0]      idx_reg [TABLE_COUNT];
    logic [INDEX_BITS-1:0]      idx_next [TABLE_COUNT];
    logic [TAG_WIDTH-1:0]       tag_reg [TABLE_COUNT];
    logic [TAG_WIDTH-1:0]       tag_next [TABLE_COUNT];
    logic [BASE_INDEX_BITS-1:0] sv_base_reg, sv_base_next;
    logic [TW-1:0]              sv_table_reg, sv_table_next;
    logic [INDEX_BITS-1:0]      sv_idx_reg, sv_idx_next;
    logic                       sv_found_reg, sv_found_next;
    logic                       sv_used_reg, sv_used_next;
    logic [PB-1:0]              fwd_pred_reg, fwd_pred_next;
    logic [1:0]                 fwd_use_reg, fwd_use_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_pred_reg, out_pred_next;
    logic                       out_tagged_reg, out_tagged_next;
    logic [TW-1:0]              out_prov_reg, out_prov_next;

    logic                       accept, out_free, upd_correct;
    logic [LEN_WIDTH-1:0]       tlen [TABLE_COUNT];
    logic [INDEX_BITS-1:0]      idx_calc [TABLE_COUNT];
    logic [TAG_WIDTH-1:0]       tag_calc [TABLE_COUNT];
    logic [IN_WIDTH-1:0]        in_word;

    assign in_word       = s_axis_tdata;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, 2'(out_prov_reg), out_tagged_reg, out_pred_reg};

    // Per-table index and tag for the arriving address and current history.
    always_comb
    begin
        for (int t = 0; t < TABLE_COUNT; t++) begin
            tlen[t]     = len_reg[(t < LEN_REGS) ? t : LEN_REGS - 1];
            idx_calc[t] = in_word[2 +: INDEX_BITS] ^ fold_hist(hist_reg, tlen[t]);
            tag_calc[t] = in_word[2 + INDEX_BITS +: TAG_WIDTH] ^ tag_hist(hist_reg, tlen[t]);
        end
    end

    // Whether found entry (else trained base) is right, used by both blocks below.
    always_comb
    begin
        logic [1:0] nb;
        nb = bump2(rd_base, taken_reg);
        if (sv_found_reg) begin
            upd_correct = (rd_pred[sv_table_reg] >= PRED_MID) == taken_reg;
        end else begin
            upd_correct = (nb >= 2'd1) == taken_reg;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (&cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept) begin
                    state_next = (s_axis_tuser == OP_UPDATE) ? ST_UPD1 : ST_PRED;
                end
            end
            ST_PRED:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_UPD1:
            begin
                state_next = upd_correct ? ST_IDLE : ST_UPD2;
            end
            ST_UPD2:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        logic          found, used, done;
        logic [TW-1:0] ptab;
        logic [INDEX_BITS-1:0] pidx;
        logic          pred;
        logic [1:0]    nb;
        logic [PB-1:0] cur_pred [TABLE_COUNT];
        logic [1:0]    cur_use  [TABLE_COUNT];
        int            start;
        logic          alloc;

        found = 1'b0;
        used  = 1'b0;
        done  = 1'b0;
        ptab  = '0;
        pidx  = '0;
        pred  = 1'b0;
        nb    = bump2(rd_base, taken_reg);
        start = 0;
        alloc = 1'b0;

        base_re    = 1'b0;
        base_raddr = sv_base_reg;
        base_we    = 1'b0;
        base_waddr = sv_base_reg;
        base_wdata = nb;
        for (int t = 0; t < TABLE_COUNT; t++) begin
            tbl_re[t]    = 1'b0;
            tbl_raddr[t] = idx_calc[t];
            tbl_we[t]    = 1'b0;
            tbl_waddr[t] = idx_reg[t];
            tbl_wtag[t]  = rd_tag[t];
            tbl_wpred[t] = rd_pred[t];
            tbl_wuse[t]  = rd_use[t];
            idx_next[t]  = idx_reg[t];
            tag_next[t]  = tag_reg[t];
            cur_pred[t]  = rd_pred[t];
            cur_use[t]   = rd_use[t];
        end

        hist_next       = hist_reg;
        op_next         = op_reg;
        taken_next      = taken_reg;
        bidx_next       = bidx_reg;
        sv_base_next    = sv_base_reg;
        sv_table_next   = sv_table_reg;
        sv_idx_next     = sv_idx_reg;
        sv_found_next   = sv_found_reg;
        sv_used_next    = sv_used_reg;
        fwd_pred_next   = fwd_pred_reg;
        fwd_use_next    = fwd_use_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_pred_next   = out_pred_reg;
        out_tagged_next = out_tagged_reg;
        out_prov_next   = out_prov_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                base_we    = 1'b1;
                base_waddr = cnt_reg[BASE_INDEX_BITS-1:0];
                base_wdata = 2'd0;
                for (int t = 0; t < TABLE_COUNT; t++) begin
                    tbl_we[t]    = 1'b1;
                    tbl_waddr[t] = cnt_reg[INDEX_BITS-1:0];
                    tbl_wtag[t]  = '0;
                    tbl_wpred[t] = '0;
                    tbl_wuse[t]  = 2'd0;
                end
            end
            ST_IDLE:
            begin
                if (accept) begin
                    op_next    = s_axis_tuser;
                    taken_next = in_word[64];
                    bidx_next  = in_word[2 +: BASE_INDEX_BITS];
                    base_re    = 1'b1;
                    base_raddr = (s_axis_tuser == OP_UPDATE) ? sv_base_reg
                                                             : in_word[2 +: BASE_INDEX_BITS];
                    for (int t = 0; t < TABLE_COUNT; t++) begin
                        tbl_re[t]   = 1'b1;
                        idx_next[t] = idx_calc[t];
                        tag_next[t] = tag_calc[t];
                        // An update reads the provider's saved entry first.
                        if (s_axis_tuser == OP_UPDATE && sv_found_reg
                            && sv_table_reg == TW'(t)) begin
                            tbl_raddr[t] = sv_idx_reg;
                        end
                    end
                end
            end
            ST_PRED:
            begin
                pred = (rd_base >= 2'd1);
                for (int t = TABLE_COUNT - 1; t >= 0; t--) begin
                    if (!done && rd_tag[t] == tag_reg[t]) begin
                        if (!found) begin
                            found = 1'b1;
                            ptab  = TW'(t);
                            pidx  = idx_reg[t];
                        end
                        // A weak entry that has never been useful is skipped.
                        if (!(rd_pred[t] == PRED_MID && rd_use[t] == 2'd0)) begin
                            pred = (rd_pred[t] >= PRED_MID);
                            used = 1'b1;
                            done = 1'b1;
                            out_prov_next = TW'(t);
                        end
                    end
                end
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_pred_next   = pred;
                    out_tagged_next = used;
                    if (!used) begin
                        out_prov_next = '0;
                    end
                    sv_base_next    = bidx_reg;
                    sv_found_next   = found;
                    sv_used_next    = used;
                    if (found) begin
                        sv_table_next = ptab;
                        sv_idx_next   = pidx;
                    end
                end else begin
                    out_prov_next = out_prov_reg;
                end
            end
            ST_UPD1:
            begin
                if (sv_found_reg) begin
                    tbl_we[sv_table_reg]    = 1'b1;
                    tbl_waddr[sv_table_reg] = sv_idx_reg;
                    tbl_wpred[sv_table_reg] = bump_pred(rd_pred[sv_table_reg], taken_reg);
                    tbl_wuse[sv_table_reg]  = bump2(rd_use[sv_table_reg], upd_correct);
                    fwd_pred_next = bump_pred(rd_pred[sv_table_reg], taken_reg);
                    fwd_use_next  = bump2(rd_use[sv_table_reg], upd_correct);
                end else begin
                    base_we = 1'b1;
                end
                if (upd_correct) begin
                    hist_next = {hist_reg[HISTORY_BITS-2:0], taken_reg};
                end else if (sv_found_reg) begin
                    tbl_re[sv_table_reg]    = 1'b1;
                    tbl_raddr[sv_table_reg] = idx_reg[sv_table_reg];
                end
            end
            ST_UPD2:
            begin
                // The entry trained last cycle is forwarded when the allocation
                // index meets it again.
                if (sv_found_reg && idx_reg[sv_table_reg] == sv_idx_reg) begin
                    cur_pred[sv_table_reg] = fwd_pred_reg;
                    cur_use[sv_table_reg]  = fwd_use_reg;
                end
                start = sv_used_reg ? int'(sv_table_reg) + 1 : 0;
                for (int t = 0; t < TABLE_COUNT; t++) begin
                    if (t >= start && !alloc && cur_use[t] == 2'd0) begin
                        alloc        = 1'b1;
                        tbl_we[t]    = 1'b1;
                        tbl_wtag[t]  = tag_reg[t];
                        tbl_wpred[t] = taken_reg ? PRED_MID + 1'b1 : PRED_MID - 1'b1;
                        tbl_wuse[t]  = cur_use[t];
                    end
                end
                if (!alloc) begin
                    for (int t = 0; t < TABLE_COUNT; t++) begin
                        if (t >= start) begin
                            tbl_we[t]    = 1'b1;
                            tbl_wpred[t] = cur_pred[t];
                            tbl_wuse[t]  = bump2(cur_use[t], 1'b0);
                        end
                    end
                end
                hist_next = {hist_reg[HISTORY_BITS-2:0], taken_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (base_we) begin
            base_mem[base_waddr] <= base_wdata;
        end
        if (base_re) begin
            rd_base <= base_mem[base_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < TABLE_COUNT; t++) begin
            if (tbl_we[t]) begin
                tag_mem[t][tbl_waddr[t]]  <= tbl_wtag[t];
                pred_mem[t][tbl_waddr[t]] <= tbl_wpred[t];
                use_mem[t][tbl_waddr[t]]  <= tbl_wuse[t];
            end
            if (tbl_re[t]) begin
                rd_tag[t]  <= tag_mem[t][tbl_raddr[t]];
                rd_pred[t] <= pred_mem[t][tbl_raddr[t]];
                rd_use[t]  <= use_mem[t][tbl_raddr[t]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            hist_reg      <= '0;
            len_reg[0]    <= LEN_WIDTH'(5);
            len_reg[1]    <= LEN_WIDTH'(12);
            len_reg[2]    <= LEN_WIDTH'(27);
            len_reg[3]    <= LEN_WIDTH'(60);
            sv_base_reg   <= '0;
            sv_table_reg  <= '0;
            sv_idx_reg    <= '0;
            sv_found_reg  <= 1'b0;
            sv_used_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            hist_reg      <= hist_next;
            sv_base_reg   <= sv_base_next;
            sv_table_reg  <= sv_table_next;
            sv_idx_reg    <= sv_idx_next;
            sv_found_reg  <= sv_found_next;
            sv_used_reg   <= sv_used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LEN_T0: len_reg[0] <= cfg_data;
                    CFG_LEN_T1: len_reg[1] <= cfg_data;
                    CFG_LEN_T2: len_reg[2] <= cfg_data;
                    CFG_LEN_T3: len_reg[3] <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        taken_reg      <= taken_next;
        bidx_reg       <= bidx_next;
        fwd_pred_reg   <= fwd_pred_next;
        fwd_use_reg    <= fwd_use_next;
        out_pred_reg   <= out_pred_next;
        out_tagged_reg <= out_tagged_next;
        out_prov_reg   <= out_prov_next;
        for (int t = 0; t < TABLE_COUNT; t++) begin
            idx_reg[t] <= idx_next[t];
            tag_reg[t] <= tag_next[t];
        end
    end

    // A result only ever appears at the end of a prediction.
    a_result_from_predict: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_PRED)
        else $error("result raised outside a prediction");

    // Allocation always follows the training step of the same update.
    a_upd2_after_upd1: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD2 |-> $past(state_reg) == ST_UPD1 && $past(op_reg) == OP_UPDATE)
        else $error("allocation step without training step");

    // A prediction never writes the base table or the first tagged table.
    a_predict_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PRED |-> !base_we && !tbl_we[0])
        else $error("table written during prediction");

    // The history moves only when an update finishes.
    a_history_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        hist_reg != $past(hist_reg) |->
            $past(state_reg) == ST_UPD1 || $past(state_reg) == ST_UPD2)
        else $error("history changed outside an update");

endmodule
